// ----- rtl/core/ent_pkg.sv -----
package ent_pkg;

    localparam int NODES_DEFAULT = 1024;

    localparam int OP_W       = 4;
    localparam int NODE_W     = 10;
    localparam int CODE_W     = 3;
    localparam int CNT_W      = 11;
    localparam int NUM_CNT    = 6;
    localparam int CFG_AW     = 3;
    localparam int STRAT_SPAN = 3;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 80;

    localparam logic [OP_W-1:0] OP_DISCOVER1 = 4'd0;
    localparam logic [OP_W-1:0] OP_REMOVE1   = 4'd1;
    localparam logic [OP_W-1:0] OP_INFECT1   = 4'd2;
    localparam logic [OP_W-1:0] OP_RECOVER1  = 4'd3;
    localparam logic [OP_W-1:0] OP_DISCOVER2 = 4'd4;
    localparam logic [OP_W-1:0] OP_REMOVE2   = 4'd5;
    localparam logic [OP_W-1:0] OP_INFECT2   = 4'd6;
    localparam logic [OP_W-1:0] OP_RECOVER2  = 4'd7;
    localparam logic [OP_W-1:0] OP_CHANGE    = 4'd8;

    localparam logic [CODE_W-1:0] CODE_S1 = 3'd0;
    localparam logic [CODE_W-1:0] CODE_I1 = 3'd1;
    localparam logic [CODE_W-1:0] CODE_R1 = 3'd2;
    localparam logic [CODE_W-1:0] CODE_S2 = 3'd3;
    localparam logic [CODE_W-1:0] CODE_I2 = 3'd4;
    localparam logic [CODE_W-1:0] CODE_R2 = 3'd5;

    typedef struct packed {
        logic clr;
        logic load;
        logic exec;
    } ent_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } ent_sts_t;

    // compartment an event leads to; also the counter that grows
    function automatic logic [CODE_W-1:0] op_dest(input logic [OP_W-1:0] op);
        logic [CODE_W-1:0] c;
        case (op)
            OP_DISCOVER1: c = CODE_S1;
            OP_REMOVE1:   c = CODE_R1;
            OP_INFECT1:   c = CODE_I1;
            OP_RECOVER1:  c = CODE_R1;
            OP_DISCOVER2: c = CODE_S2;
            OP_REMOVE2:   c = CODE_R2;
            OP_INFECT2:   c = CODE_I2;
            OP_RECOVER2:  c = CODE_R2;
            default:      c = CODE_S1;
        endcase
        return c;
    endfunction

    // counter that shrinks on an event
    function automatic logic [CODE_W-1:0] op_src(input logic [OP_W-1:0] op);
        logic [CODE_W-1:0] c;
        case (op)
            OP_DISCOVER1: c = CODE_R1;
            OP_REMOVE1:   c = CODE_S1;
            OP_INFECT1:   c = CODE_S1;
            OP_RECOVER1:  c = CODE_I1;
            OP_DISCOVER2: c = CODE_R2;
            OP_REMOVE2:   c = CODE_S2;
            OP_INFECT2:   c = CODE_S2;
            OP_RECOVER2:  c = CODE_I2;
            default:      c = CODE_S1;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/ent_ctrl.sv -----
module ent_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_tvalid,
    output logic              in_tready,
    input  ent_pkg::ent_sts_t sts,
    output ent_pkg::ent_cmd_t cmd
);
    import ent_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_tready = (state_reg == ST_IDLE);
    assign cmd.clr   = (state_reg == ST_CLEAR);
    assign cmd.load  = (state_reg == ST_IDLE) && in_tvalid;
    assign cmd.exec  = (state_reg == ST_EXEC) && !sts.out_busy;

endmodule

// ----- rtl/core/ent_datapath.sv -----
module ent_datapath #(
    parameter int NODES = ent_pkg::NODES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ent_pkg::ent_cmd_t            cmd,
    output ent_pkg::ent_sts_t            sts,
    input  logic [ent_pkg::IN_W-1:0]     in_tdata,
    input  logic                         cfg_we,
    input  logic [ent_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [ent_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic                         out_tready,
    output logic                         out_tvalid,
    output logic [ent_pkg::OUT_W-1:0]    out_tdata
);
    import ent_pkg::*;

    localparam int DEPTH = (NODES < (2 ** NODE_W)) ? NODES : (2 ** NODE_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(NODES + 1);

    logic [CODE_W-1:0] mem [DEPTH];

    logic [CODE_W-1:0] rd_code_reg;
    logic [OP_W-1:0]   op_reg;
    logic [AW-1:0]     addr_reg;
    logic              node_ok_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [CNT_W-1:0]  cfg_reg [NUM_CNT];
    logic [CNT_W-1:0]  cfg_next [NUM_CNT];
    logic [CW-1:0]     cnt_reg [NUM_CNT];
    logic [CW-1:0]     cnt_next [NUM_CNT];
    logic [CODE_W-1:0] state_reg;
    logic              out_valid_reg;

    logic [OP_W-1:0]   in_op;
    logic [NODE_W-1:0] in_node;
    logic              in_node_ok;
    logic              cfg_hit;
    logic [CODE_W-1:0] new_code;
    logic [CODE_W-1:0] src;
    logic [CODE_W-1:0] dst;
    logic              move;
    logic [CW+1:0]     total_sum;
    logic [CW+1:0]     total_sat;

    function automatic logic [CNT_W-1:0] to_field(input logic [CW+1:0] v);
        logic [CW+CNT_W+1:0] w;
        w = {{CNT_W{1'b0}}, v};
        return w[CNT_W-1:0];
    endfunction

    assign in_op      = in_tdata[OP_W-1:0];
    assign in_node    = in_tdata[OP_W +: NODE_W];
    assign in_node_ok = (32'(in_node) < 32'(NODES));
    assign cfg_hit    = cfg_we && (cfg_addr < CFG_AW'(NUM_CNT));

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            mem[clr_addr_reg] <= CODE_S1;
        end
        else if (cmd.exec && node_ok_reg)
        begin
            mem[addr_reg] <= new_code;
        end
        if (cmd.load)
        begin
            rd_code_reg <= mem[in_node[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_op;
            addr_reg    <= in_node[AW-1:0];
            node_ok_reg <= in_node_ok;
        end
        if (cmd.exec)
        begin
            state_reg <= new_code;
        end
    end

    always_comb
    begin
        new_code = rd_code_reg;
        src      = rd_code_reg;
        dst      = rd_code_reg;
        move     = 1'b0;
        if (!node_ok_reg)
        begin
            new_code = CODE_S1;
        end
        else if (op_reg < OP_CHANGE)
        begin
            new_code = op_dest(op_reg);
            src      = op_src(op_reg);
            dst      = op_dest(op_reg);
            move     = 1'b1;
        end
        else if (op_reg == OP_CHANGE && rd_code_reg < CODE_W'(NUM_CNT))
        begin
            if (rd_code_reg < CODE_W'(STRAT_SPAN))
            begin
                dst = rd_code_reg + CODE_W'(STRAT_SPAN);
            end
            else
            begin
                dst = rd_code_reg - CODE_W'(STRAT_SPAN);
            end
            new_code = dst;
            move     = 1'b1;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CNT; k++)
        begin
            cfg_next[k] = cfg_reg[k];
            if (cfg_hit && cfg_addr == CFG_AW'(k))
            begin
                cfg_next[k] = cfg_wdata;
            end
        end
        for (int k = 0; k < NUM_CNT; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            if (cfg_hit)
            begin
                cnt_next[k] = (32'(cfg_next[k]) > 32'(NODES)) ? CW'(NODES) : CW'(cfg_next[k]);
            end
            else if (cmd.exec && move)
            begin
                if (src == CODE_W'(k) && cnt_reg[k] != '0)
                begin
                    cnt_next[k] = cnt_reg[k] - CW'(1);
                end
                else if (dst == CODE_W'(k) && cnt_reg[k] < CW'(NODES))
                begin
                    cnt_next[k] = cnt_reg[k] + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CNT; k++)
            begin
                cfg_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < NUM_CNT; k++)
            begin
                cfg_reg[k] <= cfg_next[k];
                cnt_reg[k] <= cnt_next[k];
            end
            if (cmd.clr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign total_sum = {2'b0, cnt_reg[CODE_S2]} + {2'b0, cnt_reg[CODE_I2]}
                     + {2'b0, cnt_reg[CODE_R2]};
    assign total_sat = (32'(total_sum) > 32'(NODES)) ? (CW+2)'(NODES) : total_sum;

    always_comb
    begin
        out_tdata                = '0;
        out_tdata[CODE_W-1:0]    = state_reg;
        for (int k = 0; k < NUM_CNT; k++)
        begin
            out_tdata[CODE_W + k * CNT_W +: CNT_W] = to_field({2'b0, cnt_reg[k]});
        end
        out_tdata[CODE_W + NUM_CNT * CNT_W +: CNT_W] = to_field(total_sat);
    end

    assign out_tvalid   = out_valid_reg;
    assign sts.clr_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign sts.out_busy = out_valid_reg && !out_tready;

endmodule

// ----- rtl/core/epidemic_node_state_tracker.sv -----
// Two-strategy SIR node state tracker.
// Input stream s_axis: one event word per transfer (op, node). Output stream
// m_axis: one result word per event (new code, six counts, strategy-two total).
// Configuration: cfg_we/cfg_addr/cfg_wdata; writing register 0..5 stores it and
// reloads all six counters from the stored values, clamped to NODES. Write only
// while no event is in flight.
// Processing: the accepted event's node code is read from the code memory into
// a register; then the new code is written, the count moved and the output
// register loaded once no pending result is stalled. s_axis_tready is high only
// while no event is being worked on, so events are accepted one at a time.
// A stalled result holds m_axis_tdata; the next event may be accepted and
// read, then waits until the pending result is taken.
// Reset: counters, configuration registers, sweep address and output valid go
// to zero, then the code memory is swept to susceptible/strategy one, one entry
// a cycle, over min(NODES, 1024) entries; s_axis_tready stays low during the
// sweep. Configuration writes are taken.
module epidemic_node_state_tracker #(
    parameter int NODES = ent_pkg::NODES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [3:0] op, [13:4] node, [15:14] zero
    input  logic [ent_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [2:0] new_state, [13:3] count_s1, [24:14] count_i1, [35:25] count_r1,
    // [46:36] count_s2, [57:47] count_i2, [68:58] count_r2,
    // [79:69] countermeasure_total
    output logic [ent_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        cfg_we,
    input  logic [ent_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [ent_pkg::CNT_W-1:0]   cfg_wdata
);
    import ent_pkg::*;

    ent_cmd_t cmd;
    ent_sts_t sts;

    ent_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ent_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_tdata   (s_axis_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tdata  (m_axis_tdata)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("event accepted while another is in flight");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> !s_axis_tready)
        else $error("input ready during memory sweep");

    a_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CODE_W-1:0] <= CODE_R2))
        else $error("result carries an undefined node code");

endmodule
